>>> src/bmg_pkg.sv
package bmg_pkg;

    // Field and datapath widths
    localparam int IN_W    = 32;
    localparam int OUT_W   = 22;
    localparam int T_W     = 40;          // -2 ln u1, Q32
    localparam int SQ_IN_W = T_W + 16;    // radicand, Q48
    localparam int R_W     = SQ_IN_W / 2; // root, Q24

    // Default parameter values
    localparam int UNIFORM_BITS_DEF  = 32;
    localparam int OUT_FRAC_BITS_DEF = 16;

    // Arithmetic constants
    localparam logic [31:0]    LN2_Q32    = 32'hB172_17F8;
    localparam logic [31:0]    PI_Q30     = 32'hC90F_DAA2;
    localparam logic [T_W-1:0] TINY_T_Q32 = 40'd237348664096;

    // Taylor term steps: sine terms first, then cosine terms
    localparam logic [3:0] SIN_LAST = 4'd4;
    localparam logic [3:0] COS_LAST = 4'd10;

    typedef struct packed {
        logic [IN_W-1:0] first_uniform;
        logic [IN_W-1:0] second_uniform;
    } req_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] gauss_sample;
        logic                    was_spare;
    } smp_t;

    // Reciprocal for the term divisor: ceil(2^S / d), S = 30 + ceil(log2 d).
    // Exact floor division for numerators below 2^30.
    function automatic logic [31:0] div_mul(input logic [3:0] step);
        logic [31:0] m;
        unique case (step)
            4'd0:    m = 32'(((64'd1 << 33) + 64'd5)   / 64'd6);
            4'd1:    m = 32'(((64'd1 << 35) + 64'd19)  / 64'd20);
            4'd2:    m = 32'(((64'd1 << 36) + 64'd41)  / 64'd42);
            4'd3:    m = 32'(((64'd1 << 37) + 64'd71)  / 64'd72);
            4'd4:    m = 32'(((64'd1 << 37) + 64'd109) / 64'd110);
            4'd5:    m = 32'(((64'd1 << 31) + 64'd1)   / 64'd2);
            4'd6:    m = 32'(((64'd1 << 34) + 64'd11)  / 64'd12);
            4'd7:    m = 32'(((64'd1 << 35) + 64'd29)  / 64'd30);
            4'd8:    m = 32'(((64'd1 << 36) + 64'd55)  / 64'd56);
            4'd9:    m = 32'(((64'd1 << 37) + 64'd89)  / 64'd90);
            4'd10:   m = 32'(((64'd1 << 38) + 64'd131) / 64'd132);
            default: m = 32'd0;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] div_shift(input logic [3:0] step);
        logic [5:0] s;
        unique case (step)
            4'd0:    s = 6'd33;
            4'd1:    s = 6'd35;
            4'd2:    s = 6'd36;
            4'd3:    s = 6'd37;
            4'd4:    s = 6'd37;
            4'd5:    s = 6'd31;
            4'd6:    s = 6'd34;
            4'd7:    s = 6'd35;
            4'd8:    s = 6'd36;
            4'd9:    s = 6'd37;
            4'd10:   s = 6'd38;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    // Odd terms of each series subtract
    function automatic logic term_sub(input logic [3:0] step);
        logic sub;
        unique case (step) inside
            4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9: sub = 1'b1;
            default:                            sub = 1'b0;
        endcase
        return sub;
    endfunction

endpackage

>>> src/bmg_sqrt.sv
module bmg_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bmg_pkg::SQ_IN_W-1:0]   operand,
    output logic                          busy,
    output logic [bmg_pkg::R_W-1:0]       root
);

    localparam int CNT_W = $clog2(bmg_pkg::R_W);

    logic                          busy_reg, busy_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [bmg_pkg::SQ_IN_W-1:0]   op_reg, op_next;
    logic [bmg_pkg::R_W-1:0]       root_reg, root_next;
    logic [bmg_pkg::R_W+1:0]       rem_reg, rem_next;
    logic [bmg_pkg::R_W+3:0]       rem_sh;
    logic [bmg_pkg::R_W+3:0]       trial;

    // two radicand bits per cycle, one root bit out
    assign rem_sh = {rem_reg, op_reg[bmg_pkg::SQ_IN_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = operand;
            root_next = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            op_next = op_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_next  = (bmg_pkg::R_W + 2)'(rem_sh - trial);
                root_next = {root_reg[bmg_pkg::R_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = (bmg_pkg::R_W + 2)'(rem_sh);
                root_next = {root_reg[bmg_pkg::R_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(bmg_pkg::R_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        op_reg   <= op_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

>>> src/box_muller_gaussian_pair_top.sv
// Box-Muller normal sample generator with a one-sample spare.
// Request channel (req_valid / req_stall / req_data): two uniform fractions
// u1 and u2. Result channel (smp_valid / smp_stall / smp_data): one signed
// sample per request, 16 fraction bits by default, saturated, plus a flag
// that marks a returned spare.
//
// A request answered from a held spare has its result in the output
// register in the cycle after acceptance; u1 and u2 are dropped. Otherwise
// the block normalizes u1, forms -2 ln u1 in 32 squaring steps on the
// shared 32x32 multiplier, starts the 28-step square root unit and
// meanwhile runs the angle and the sine / cosine series (24 multiplies) on
// the same multiplier; two final multiplies scale cosine and sine by the
// root. One request is in work at a time; the next is taken only after
// the result loads.
//
// Reset clears the spare and the output valid. A stalled result holds its
// value; the next computation finishes and waits for the output register
// to free. A spare request waits until the output register is empty.
module box_muller_gaussian_pair_top #(
    parameter int UNIFORM_BITS  = bmg_pkg::UNIFORM_BITS_DEF,
    parameter int OUT_FRAC_BITS = bmg_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bmg_pkg::req_t req_data,
    output logic          smp_valid,
    input  logic          smp_stall,
    output bmg_pkg::smp_t smp_data
);

    localparam int OW     = bmg_pkg::OUT_W;
    localparam int RND_SH = 54 - OUT_FRAC_BITS;
    localparam int SH_R   = (UNIFORM_BITS >= 32) ? UNIFORM_BITS - 32 : 0;
    localparam int SH_L   = (UNIFORM_BITS < 32) ? 32 - UNIFORM_BITS : 0;
    localparam logic [31:0] U_MASK = (UNIFORM_BITS >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << UNIFORM_BITS) - 64'd1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_NORM   = 4'd1;
    localparam logic [3:0] S_LOG    = 4'd2;
    localparam logic [3:0] S_THI    = 4'd3;
    localparam logic [3:0] S_TLO    = 4'd4;
    localparam logic [3:0] S_SQST   = 4'd5;
    localparam logic [3:0] S_ANG    = 4'd6;
    localparam logic [3:0] S_X2     = 4'd7;
    localparam logic [3:0] S_TMUL   = 4'd8;
    localparam logic [3:0] S_TDIV   = 4'd9;
    localparam logic [3:0] S_SQWAIT = 4'd10;
    localparam logic [3:0] S_SC_C   = 4'd11;
    localparam logic [3:0] S_SC_S   = 4'd12;
    localparam logic [3:0] S_EMIT   = 4'd13;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // control
    logic [3:0]              state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    bmg_pkg::smp_t           out_data_reg, out_data_next;
    logic                    spare_valid_reg, spare_valid_next;
    logic [OW-1:0]           spare_value_reg, spare_value_next;

    // datapath
    logic [31:0]             norm_reg, norm_next;
    logic [4:0]              pos_reg, pos_next;
    logic [30:0]             m_reg, m_next;
    logic [31:0]             frac_reg, frac_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic [37:0]             acc_reg, acc_next;
    logic [bmg_pkg::T_W-1:0] t_reg, t_next;
    logic [1:0]              quad_reg, quad_next;
    logic                    swap_reg, swap_next;
    logic [29:0]             d_reg, d_next;
    logic [29:0]             x_reg, x_next;
    logic [29:0]             x2_reg, x2_next;
    logic [30:0]             term_reg, term_next;
    logic [29:0]             n_reg, n_next;
    logic [3:0]              step_reg, step_next;
    logic signed [31:0]      sum_reg, sum_next;
    logic signed [31:0]      sin_reg, sin_next;
    logic signed [31:0]      cos_reg, cos_next;
    logic [bmg_pkg::R_W-1:0] r_reg, r_next;
    logic [OW-1:0]           cos_out_reg, cos_out_next;

    // shared multiplier
    logic [31:0]             mul_a, mul_b;
    logic [63:0]             prod;

    logic                    req_take, out_free;
    logic [31:0]             u1m, u2m, ang;
    logic [29:0]             ang_rem;
    logic [6:0]              hi7;
    logic [31:0]             msq;
    logic [38:0]             tsum;
    logic [63:0]             qdiv;
    logic [30:0]             qv;
    logic signed [31:0]      sum_upd;
    logic signed [31:0]      s0, c0, cv, sv, trig;
    logic                    trig_neg;
    logic [31:0]             trig_mag;
    logic [OW-1:0]           scaled;
    logic                    sqrt_start, sqrt_busy;
    logic [bmg_pkg::R_W-1:0] sqrt_root;

    // round half away from zero, then saturate to the output range
    function automatic logic [OW-1:0] scale_q(input logic [63:0] p, input logic neg);
        logic [63:0] q;
        logic [63:0] lim;
        q   = (p + (64'd1 << (RND_SH - 1))) >> RND_SH;
        lim = neg ? (64'd1 << (OW - 1)) : ((64'd1 << (OW - 1)) - 64'd1);
        if (q > lim)
        begin
            q = lim;
        end
        return neg ? OW'(-q) : OW'(q);
    endfunction

    assign req_take = req_valid && !req_stall;
    assign out_free = !out_valid_reg || !smp_stall;
    assign req_stall = (state_reg != S_IDLE) || (spare_valid_reg && out_valid_reg);

    assign u1m     = req_data.first_uniform & U_MASK;
    assign u2m     = req_data.second_uniform & U_MASK;
    assign ang     = (UNIFORM_BITS >= 32) ? (u2m >> SH_R) : (u2m << SH_L);
    assign ang_rem = ang[29:0];

    assign hi7 = 7'(UNIFORM_BITS) - {2'b00, pos_reg} - {6'd0, (frac_reg != 32'd0)};

    // quadrant fold; upper half of a quadrant swaps sine and cosine
    always_comb
    begin
        s0 = swap_reg ? cos_reg : sin_reg;
        c0 = swap_reg ? sin_reg : cos_reg;
        case (quad_reg)
            QUAD_0:
            begin
                cv = c0;
                sv = s0;
            end
            QUAD_1:
            begin
                cv = -s0;
                sv = c0;
            end
            QUAD_2:
            begin
                cv = -c0;
                sv = -s0;
            end
            default:
            begin
                cv = s0;
                sv = -c0;
            end
        endcase
    end

    assign trig     = (state_reg == S_SC_C) ? cv : sv;
    assign trig_neg = trig[31];
    assign trig_mag = trig_neg ? 32'(-trig) : 32'(trig);

    // operand select for the one multiplier
    always_comb
    begin
        unique case (state_reg)
            S_LOG:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            S_THI:
            begin
                mul_a = 32'(hi7);
                mul_b = bmg_pkg::LN2_Q32;
            end
            S_TLO:
            begin
                mul_a = 32'(-frac_reg);
                mul_b = bmg_pkg::LN2_Q32;
            end
            S_ANG:
            begin
                mul_a = {1'b0, d_reg, 1'b0};
                mul_b = bmg_pkg::PI_Q30;
            end
            S_X2:
            begin
                mul_a = {2'b00, x_reg};
                mul_b = {2'b00, x_reg};
            end
            S_TMUL:
            begin
                mul_a = {1'b0, term_reg};
                mul_b = {2'b00, x2_reg};
            end
            S_TDIV:
            begin
                mul_a = {2'b00, n_reg};
                mul_b = bmg_pkg::div_mul(step_reg);
            end
            S_SC_C, S_SC_S:
            begin
                mul_a = 32'(r_reg);
                mul_b = trig_mag;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    assign msq     = prod[61:30];
    assign tsum    = 39'(acc_reg) + 39'(prod[63:32]);
    assign qdiv    = prod >> bmg_pkg::div_shift(step_reg);
    assign qv      = qdiv[30:0];
    assign sum_upd = bmg_pkg::term_sub(step_reg) ? (sum_reg - $signed({1'b0, qv}))
                                                 : (sum_reg + $signed({1'b0, qv}));
    assign scaled  = scale_q(prod, trig_neg);

    assign sqrt_start = (state_reg == S_SQST);

    bmg_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand ({t_reg, 16'd0}),
        .busy    (sqrt_busy),
        .root    (sqrt_root)
    );

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && smp_stall;
        out_data_next    = out_data_reg;
        spare_valid_next = spare_valid_reg;
        spare_value_next = spare_value_reg;
        norm_next        = norm_reg;
        pos_next         = pos_reg;
        m_next           = m_reg;
        frac_next        = frac_reg;
        cnt_next         = cnt_reg;
        acc_next         = acc_reg;
        t_next           = t_reg;
        quad_next        = quad_reg;
        swap_next        = swap_reg;
        d_next           = d_reg;
        x_next           = x_reg;
        x2_next          = x2_reg;
        term_next        = term_reg;
        n_next           = n_reg;
        step_next        = step_reg;
        sum_next         = sum_reg;
        sin_next         = sin_reg;
        cos_next         = cos_reg;
        r_next           = r_reg;
        cos_out_next     = cos_out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    if (spare_valid_reg)
                    begin
                        out_valid_next             = 1'b1;
                        out_data_next.gauss_sample = spare_value_reg;
                        out_data_next.was_spare    = 1'b1;
                        spare_valid_next           = 1'b0;
                    end
                    else
                    begin
                        quad_next = ang[31:30];
                        swap_next = ang_rem[29];
                        d_next    = ang_rem[29] ? (30'h2000_0000 - {1'b0, ang_rem[28:0]})
                                                : ang_rem;
                        if (u1m == 32'd0)
                        begin
                            t_next     = bmg_pkg::TINY_T_Q32;
                            state_next = S_SQST;
                        end
                        else
                        begin
                            norm_next  = u1m;
                            pos_next   = 5'd31;
                            state_next = S_NORM;
                        end
                    end
                end
            end
            S_NORM:
            begin
                if (norm_reg[31])
                begin
                    m_next     = norm_reg[31:1];
                    frac_next  = 32'd0;
                    cnt_next   = 5'd0;
                    state_next = S_LOG;
                end
                else if (norm_reg[31:24] == 8'd0)
                begin
                    norm_next = norm_reg << 8;
                    pos_next  = pos_reg - 5'd8;
                end
                else
                begin
                    norm_next = norm_reg << 1;
                    pos_next  = pos_reg - 5'd1;
                end
            end
            S_LOG:
            begin
                frac_next = {frac_reg[30:0], msq[31]};
                m_next    = msq[31] ? msq[31:1] : msq[30:0];
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = S_THI;
                end
            end
            S_THI:
            begin
                acc_next   = prod[37:0];
                state_next = S_TLO;
            end
            S_TLO:
            begin
                t_next     = {tsum, 1'b0};
                state_next = S_SQST;
            end
            S_SQST:
            begin
                state_next = S_ANG;
            end
            S_ANG:
            begin
                x_next     = prod[61:32];
                state_next = S_X2;
            end
            S_X2:
            begin
                x2_next    = prod[59:30];
                term_next  = {1'b0, x_reg};
                sum_next   = $signed({2'b00, x_reg});
                step_next  = 4'd0;
                state_next = S_TMUL;
            end
            S_TMUL:
            begin
                n_next     = prod[59:30];
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == bmg_pkg::SIN_LAST)
                begin
                    sin_next   = sum_upd;
                    term_next  = 31'h4000_0000;
                    sum_next   = 32'sh4000_0000;
                    state_next = S_TMUL;
                end
                else if (step_reg == bmg_pkg::COS_LAST)
                begin
                    cos_next   = sum_upd;
                    state_next = S_SQWAIT;
                end
                else
                begin
                    term_next  = qv;
                    sum_next   = sum_upd;
                    state_next = S_TMUL;
                end
            end
            S_SQWAIT:
            begin
                if (!sqrt_busy)
                begin
                    r_next     = sqrt_root;
                    state_next = S_SC_C;
                end
            end
            S_SC_C:
            begin
                cos_out_next = scaled;
                state_next   = S_SC_S;
            end
            S_SC_S:
            begin
                spare_value_next = scaled;
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.gauss_sample = cos_out_reg;
                    out_data_next.was_spare    = 1'b0;
                    spare_valid_next           = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
            spare_value_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
            spare_value_reg <= spare_value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        norm_reg     <= norm_next;
        pos_reg      <= pos_next;
        m_reg        <= m_next;
        frac_reg     <= frac_next;
        cnt_reg      <= cnt_next;
        acc_reg      <= acc_next;
        t_reg        <= t_next;
        quad_reg     <= quad_next;
        swap_reg     <= swap_next;
        d_reg        <= d_next;
        x_reg        <= x_next;
        x2_reg       <= x2_next;
        term_reg     <= term_next;
        n_reg        <= n_next;
        step_reg     <= step_next;
        sum_reg      <= sum_next;
        sin_reg      <= sin_next;
        cos_reg      <= cos_next;
        r_reg        <= r_next;
        cos_out_reg  <= cos_out_next;
    end

    assign smp_valid = out_valid_reg;
    assign smp_data  = out_data_reg;

endmodule

>>> sim/box_muller_gaussian_pair_top_test.sv
`timescale 1ns / 100ps

module box_muller_gaussian_pair_top_test;

    localparam int NUM_RANDOM   = 1930;
    localparam int WATCHDOG_MAX = 20000;
    localparam int DRAIN_CYCLES = 200;

    // Constants of the fixed-point pipeline
    localparam longint unsigned LN2_K    = 64'hB17217F8;
    localparam longint unsigned PI_K     = 64'hC90FDAA2;
    localparam longint unsigned TINY_T_K = 64'd237348664096;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    bmg_pkg::req_t  req_data;
    logic           smp_valid;
    logic           smp_stall;
    bmg_pkg::smp_t  smp_data;

    box_muller_gaussian_pair_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp_data  (smp_data)
    );

    // Pending requests, expected samples, bookkeeping
    bmg_pkg::req_t pending_reqs[$];
    bmg_pkg::smp_t expected_samples[$];
    bit   spare_held;
    logic signed [bmg_pkg::OUT_W-1:0] spare_sample;
    int   errors;
    int   sender_idle_pct;
    int   receiver_stall_pct;
    int   watchdog;
    int   accepted_reqs;
    int   checked_samples;
    int   spare_samples;

    // Stall value sampled at the last rising edge, with acceptance
    logic req_stall_seen;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // floor(sqrt(v)), digit by digit
    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // -2 ln(x / 2^32) in Q32, x nonzero
    function automatic longint unsigned neg_two_ln(input longint unsigned x);
        int p;
        longint unsigned m, frac, v, hi, lo;
        p = 63;
        frac = 0;
        while (p > 0 && x[p] == 1'b0) p--;
        if (p >= 30) m = x >> (p - 30);
        else         m = x << (30 - p);
        for (int i = 0; i < 32; i++)
        begin
            m = (m * m) >> 30;
            frac <<= 1;
            if (m >= (64'd1 << 31))
            begin
                m >>= 1;
                frac |= 1;
            end
        end
        v  = (longint'(bmg_pkg::UNIFORM_BITS_DEF - p) << 32) - frac;
        hi = v >> 32;
        lo = v & 64'hFFFF_FFFF;
        return 2 * (hi * LN2_K + ((lo * LN2_K) >> 32));
    endfunction

    // Taylor sine / cosine of x in Q30, 0 <= x <= pi/4
    function automatic void taylor_sincos(input longint unsigned x, output longint s,
                                          output longint c);
        longint unsigned x2, term;
        longint sum;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 5; k++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            sum += (k & 1) ? -longint'(term) : longint'(term);
        end
        s = sum;
        term = 64'd1 << 30;
        sum = longint'(term);
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            sum += (k & 1) ? -longint'(term) : longint'(term);
        end
        c = sum;
    endfunction

    // r (Q24) times trig (Q30): round half away from zero, saturate
    function automatic logic signed [bmg_pkg::OUT_W-1:0] scale_sample(
        input longint unsigned r, input longint trig);
        bit neg;
        longint unsigned mag, q, lim;
        int sh;
        neg = trig < 0;
        mag = neg ? longint'(-trig) : longint'(trig);
        sh  = 54 - bmg_pkg::OUT_FRAC_BITS_DEF;
        q   = (r * mag + (64'd1 << (sh - 1))) >> sh;
        lim = neg ? (64'd1 << (bmg_pkg::OUT_W - 1)) : ((64'd1 << (bmg_pkg::OUT_W - 1)) - 1);
        if (q > lim) q = lim;
        return neg ? -bmg_pkg::OUT_W'(q) : bmg_pkg::OUT_W'(q);
    endfunction

    // Next sample for an accepted request; updates the spare
    function automatic bmg_pkg::smp_t gauss_pair_next(input bmg_pkg::req_t rq);
        bmg_pkg::smp_t o;
        longint unsigned t, r, a, quad, rem, xr;
        longint s0, c0, sv, cv;
        if (spare_held)
        begin
            spare_held     = 1'b0;
            o.gauss_sample = spare_sample;
            o.was_spare    = 1'b1;
            return o;
        end
        t = (rq.first_uniform == 0) ? TINY_T_K : neg_two_ln(rq.first_uniform);
        r = isqrt(t << 16);
        a = rq.second_uniform;
        quad = a >> 30;
        rem = a & ((64'd1 << 30) - 1);
        if (rem < (64'd1 << 29))
        begin
            xr = (rem * (2 * PI_K)) >> 32;
            taylor_sincos(xr, s0, c0);
        end
        else
        begin
            xr = (((64'd1 << 30) - rem) * (2 * PI_K)) >> 32;
            taylor_sincos(xr, c0, s0);
        end
        case (quad)
            0:
            begin
                cv = c0;
                sv = s0;
            end
            1:
            begin
                cv = -s0;
                sv = c0;
            end
            2:
            begin
                cv = -c0;
                sv = -s0;
            end
            default:
            begin
                cv = s0;
                sv = -c0;
            end
        endcase
        spare_sample   = scale_sample(r, sv);
        spare_held     = 1'b1;
        o.gauss_sample = scale_sample(r, cv);
        o.was_spare    = 1'b0;
        return o;
    endfunction

    // Driver: present next request at the falling edge, hold while stalled
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || (req_valid && !req_stall_seen))
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    req_data  <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
            smp_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_stall_seen <= 1'b1;
            watchdog       <= 0;
        end
        else
        begin
            req_stall_seen <= req_stall;
            if (req_valid && !req_stall)
            begin
                expected_samples.push_back(gauss_pair_next(req_data));
                accepted_reqs++;
            end
            if ((req_valid && !req_stall) || (smp_valid && !smp_stall))
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;
        end
    end

    // Monitor: compare each accepted sample with the oldest expectation
    always @(posedge clk)
    begin
        bmg_pkg::smp_t exp_s;
        if (rst_n && smp_valid && !smp_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected sample actual=%0d/%0b", $time,
                         smp_data.gauss_sample, smp_data.was_spare);
                errors++;
            end
            else
            begin
                exp_s = expected_samples.pop_front();
                if (smp_data.gauss_sample !== exp_s.gauss_sample)
                begin
                    $display("%0t: gauss_sample mismatch expected=%0d actual=%0d",
                             $time, exp_s.gauss_sample, smp_data.gauss_sample);
                    errors++;
                end
                if (smp_data.was_spare !== exp_s.was_spare)
                begin
                    $display("%0t: was_spare mismatch expected=%0b actual=%0b",
                             $time, exp_s.was_spare, smp_data.was_spare);
                    errors++;
                end
                checked_samples++;
                if (exp_s.was_spare) spare_samples++;
            end
        end
    end

    // Watchdog on cycles with no progress
    always @(posedge clk)
    begin
        if (watchdog >= WATCHDOG_MAX)
        begin
            $display("Timeout after %0d idle cycles", watchdog);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic bmg_pkg::req_t make_req(input logic [31:0] u1,
                                               input logic [31:0] u2);
        bmg_pkg::req_t rq;
        rq.first_uniform  = u1;
        rq.second_uniform = u2;
        return rq;
    endfunction

    // Random u1: mostly uniform, some tiny values to drive large radii
    function automatic logic [31:0] rand_u1();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 32'($urandom_range(255));
        if (pick == 1) return $urandom >> $urandom_range(31);
        return $urandom;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_valid || expected_samples.size() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] edge_u[$];
        int phase_len;
        errors = 0;
        accepted_reqs = 0;
        checked_samples = 0;
        spare_samples = 0;
        spare_held = 1'b0;
        spare_sample = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        smp_stall = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero u1 (tiny constant), extremes, quadrant and octant
        // boundaries; pairs so both the cosine and its spare come back
        edge_u = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h2000_0000,
                   32'h1FFF_FFFF, 32'h4000_0000, 32'hC000_0000, 32'h6000_0000,
                   32'hE000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (edge_u[i])
        begin
            pending_reqs.push_back(make_req(edge_u[i], edge_u[(i * 5 + 3) % 12]));
            pending_reqs.push_back(make_req($urandom, $urandom));
        end
        wait_drained();

        // Random phases: no idling, sender idle, receiver stall, both, no idling
        phase_len = NUM_RANDOM / 5;
        for (int ph = 0; ph < 5; ph++)
        begin
            sender_idle_pct    = (ph == 1) ? 53 : (ph == 3 ? 27 : 0);
            receiver_stall_pct = (ph == 2) ? 53 : (ph == 3 ? 27 : 0);
            for (int i = 0; i < phase_len; i++)
                pending_reqs.push_back(make_req(rand_u1(), $urandom));
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d requests, %0d samples checked (%0d from spare),",
                 accepted_reqs, checked_samples, spare_samples);
        $display("under free flow, sender gaps, receiver stalls and both.");
        if (errors == 0 && expected_samples.size() == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatches, %0d samples outstanding", errors,
                     expected_samples.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
